[src/cbc_pkg.sv]
// cartridge bank controller package: mapper kinds, address windows,
// bank state and action flag structs shared by the decoder and the top level
// no dependencies
package cbc_pkg;

    // mapper kind as held in the configuration register
    typedef enum logic [2:0] {
        MAPPER_NONE    = 3'd0,
        MAPPER_MBC1    = 3'd1,
        MAPPER_MBC3    = 3'd2,
        MAPPER_MBC5    = 3'd3,
        MAPPER_UNKNOWN = 3'd4
    } mapper_kind_t;

    // 8 KiB windows of the lower 32 KiB cartridge space, address bits 14:13
    typedef enum logic [1:0] {
        REGION_RAM_ENABLE = 2'd0,
        REGION_ROM_SELECT = 2'd1,
        REGION_RAM_SELECT = 2'd2,
        REGION_MODE_LATCH = 2'd3
    } region_t;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int BANK_W = 8;
    localparam int UPPER_W = 2;
    localparam int CFG_W = 3;

    localparam logic [BANK_W-1:0] ROM_BANK_RESET = 8'h01;
    localparam logic [BANK_W-1:0] RAM_BANK_RESET = 8'h00;

    // mbc3 ram select codes
    localparam logic [DATA_W-1:0] MBC3_RAM_BANKS = 8'd4;
    localparam logic [DATA_W-1:0] MBC3_CLOCK_LO  = 8'd8;
    localparam logic [DATA_W-1:0] MBC3_CLOCK_HI  = 8'd12;

    typedef struct packed {
        logic [BANK_W-1:0]  rom_bank;
        logic [BANK_W-1:0]  ram_bank;
        logic               clock_sel;
        logic               mode;
        logic [UPPER_W-1:0] upper_rom;
    } bank_state_t;

    typedef struct packed {
        logic save_old_ram;
        logic load_new_ram;
        logic clear_window;
        logic remap_rom;
        logic ignored;
    } bank_flags_t;

    localparam bank_state_t BANK_STATE_RESET = '{
        rom_bank:  ROM_BANK_RESET,
        ram_bank:  RAM_BANK_RESET,
        clock_sel: 1'b0,
        mode:      1'b0,
        upper_rom: '0
    };

endpackage

[src/cbc_decode.sv]
// bus write decoder: next bank state and window action flags for one item
// depends on cbc_pkg
module cbc_decode
    import cbc_pkg::*;
(
    input  logic [CFG_W-1:0]  mapper_kind,
    input  bank_state_t       cur,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] data,
    output bank_state_t       nxt,
    output bank_flags_t       flags
);

    region_t           region;
    logic              ram_sel;
    logic [BANK_W-1:0] ram_val;
    logic              rom_sel;
    logic [BANK_W-1:0] rom_val;
    logic              clk_sel;
    logic              mode_wr;
    logic              upper_wr;
    logic              ignore;

    assign region = region_t'(address[14:13]);

    always_comb
    begin
        ram_sel  = 1'b0;
        ram_val  = data;
        rom_sel  = 1'b0;
        rom_val  = data;
        clk_sel  = 1'b0;
        mode_wr  = 1'b0;
        upper_wr = 1'b0;
        ignore   = 1'b0;
        if (!address[ADDR_W-1])
        begin
            case (mapper_kind)
                MAPPER_NONE:
                begin
                end
                MAPPER_MBC1:
                begin
                    case (region)
                        REGION_MODE_LATCH: mode_wr = 1'b1;
                        REGION_RAM_SELECT:
                        begin
                            if (cur.mode)
                                ram_sel = 1'b1;
                            else
                                upper_wr = 1'b1;
                        end
                        REGION_ROM_SELECT:
                        begin
                            rom_sel = 1'b1;
                            rom_val = {1'b0, (cur.mode ? 2'b00 : cur.upper_rom), data[4:0]};
                            // bank with zero low bits moves up by one
                            if (data[4:0] == 5'd0)
                                rom_val[0] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MAPPER_MBC3:
                begin
                    case (region)
                        REGION_RAM_SELECT:
                        begin
                            if (data < MBC3_RAM_BANKS)
                                ram_sel = 1'b1;
                            else if (data inside {[MBC3_CLOCK_LO:MBC3_CLOCK_HI]})
                                clk_sel = 1'b1;
                            else
                                ignore = 1'b1;
                        end
                        REGION_ROM_SELECT:
                        begin
                            rom_sel = 1'b1;
                            rom_val = {1'b0, data[6:0]};
                            if (data[6:0] == 7'd0)
                                rom_val = ROM_BANK_RESET;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MAPPER_MBC5:
                begin
                    if (region inside {REGION_RAM_SELECT, REGION_MODE_LATCH})
                        ram_sel = 1'b1;
                    else if (region == REGION_ROM_SELECT)
                        rom_sel = 1'b1;
                end
                default: ignore = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        nxt   = cur;
        flags = '0;
        flags.ignored = ignore;
        if (mode_wr)
            nxt.mode = data[0];
        if (upper_wr)
            nxt.upper_rom = data[UPPER_W-1:0];
        // ram bank change drops the clock view; write-back only of real ram
        if (ram_sel && (cur.ram_bank != ram_val))
        begin
            flags.save_old_ram = !cur.clock_sel;
            flags.load_new_ram = 1'b1;
            nxt.clock_sel      = 1'b0;
            nxt.ram_bank       = ram_val;
        end
        if (rom_sel && (cur.rom_bank != rom_val))
        begin
            flags.remap_rom = 1'b1;
            nxt.rom_bank    = rom_val;
        end
        if (clk_sel)
        begin
            flags.clear_window = 1'b1;
            nxt.clock_sel      = 1'b1;
        end
    end

endmodule

[src/cartridge_bank_controller_core.sv]
// cartridge bank controller top level: input register, write decoder,
// bank state and result register, with the mapper kind configuration register
// depends on cbc_pkg and cbc_decode
//
// the input register holds an item while it is decoded, and its result is then
//   registered in the result register; throughput: one item per cycle unless
//   the result side stalls; the bank state is updated in the same cycle the
//   item is decoded, so the next item sees it straight away; a stalled result
//   holds the input register, which can still take one more item
// reset (rst_n, asynchronous, active low): rom bank 1, ram bank 0, clock view
//   off, mode bit 0, upper rom bits 0, mapper kind none, both stages empty
module cartridge_bank_controller_core
    import cbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    // configuration: mapper kind
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,

    // bus write items
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [23:0]      s_axis_tdata,   // [15:0] address, [23:16] data

    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [7:0] rom_bank, [15:8] ram_bank, [16] clock_selected, [17] banking_mode,
    // [18] save_old_ram, [19] load_new_ram, [20] clear_window, [21] remap_rom,
    // [22] ignored, [23] zero
    output logic [23:0]      m_axis_tdata
);

    // configuration register
    logic [CFG_W-1:0]  mapper_kind_reg;

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;

    // bank state
    bank_state_t       state_reg;
    bank_state_t       state_next;
    bank_flags_t       flags;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    bank_state_t       out_state_reg;
    bank_flags_t       out_flags_reg;

    logic              advance;
    logic              process;

    // the result register can take a new item when empty or being drained
    assign advance       = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && advance;
    // input register frees up whenever its item moves on
    assign s_axis_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mapper_kind_reg <= MAPPER_NONE;
        else if (cfg_we)
            mapper_kind_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= BANK_STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
                state_reg <= state_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_addr_reg <= s_axis_tdata[15:0];
            in_data_reg <= s_axis_tdata[23:16];
        end
        if (process)
        begin
            out_state_reg <= state_next;
            out_flags_reg <= flags;
        end
    end

    // single pass decode of the item in the input register
    cbc_decode u_decode (
        .mapper_kind (mapper_kind_reg),
        .cur         (state_reg),
        .address     (in_addr_reg),
        .data        (in_data_reg),
        .nxt         (state_next),
        .flags       (flags)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_flags_reg.ignored,
                            out_flags_reg.remap_rom,
                            out_flags_reg.clear_window,
                            out_flags_reg.load_new_ram,
                            out_flags_reg.save_old_ram,
                            out_state_reg.mode,
                            out_state_reg.clock_sel,
                            out_state_reg.ram_bank,
                            out_state_reg.rom_bank};

    // a write-back is always paired with a load of the new bank
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_flags_reg.save_old_ram) |-> out_flags_reg.load_new_ram)
        else $error("save without load");

    // loading a ram bank leaves the clock view off, clearing the window turns it on
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_flags_reg.load_new_ram) |-> !out_state_reg.clock_sel)
        else $error("clock view left on after ram bank load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_flags_reg.clear_window) |-> out_state_reg.clock_sel)
        else $error("window cleared without clock view");

    // bank state only moves when an item is decoded
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(process) |-> $stable(state_reg))
        else $error("bank state changed without an item");

endmodule

[sim/cartridge_bank_controller_core_tb.sv]
// self-checking testbench for cartridge_bank_controller_core: bus write items in,
// predicted bank state and window actions compared field by field on the result side
// depends on cbc_pkg and the cartridge_bank_controller_core rtl
module cartridge_bank_controller_core_tb;
    import cbc_pkg::*;

    // one bus write as it travels on s_axis_tdata: address low, data high
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] addr;
    } bus_write_t;

    // one result as it travels on m_axis_tdata[22:0], top field first
    typedef struct packed {
        logic              ignored;
        logic              remap_rom;
        logic              clear_window;
        logic              load_new_ram;
        logic              save_old_ram;
        logic              banking_mode;
        logic              clock_selected;
        logic [BANK_W-1:0] ram_bank;
        logic [BANK_W-1:0] rom_bank;
    } bank_result_t;

    // highest code of the mapper register, an unknown kind as well
    localparam logic [CFG_W-1:0] MAPPER_KIND_TOP = '1;
    localparam int STALL_LIMIT = 2000;  // cycles with no item moving before giving up
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int NUM_PHASES  = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // predictor copy of the block state and its mapper kind
    logic [CFG_W-1:0]   model_kind = MAPPER_NONE;
    logic [BANK_W-1:0]  model_rom = ROM_BANK_RESET;
    logic [BANK_W-1:0]  model_ram = RAM_BANK_RESET;
    logic               model_clock = 1'b0;
    logic               model_mode = 1'b0;
    logic [UPPER_W-1:0] model_upper = '0;

    bus_write_t   writes_pending[$];
    bank_result_t results_due[$];
    int mismatch_count = 0;
    int idle_cycles = 0;

    // traffic shaping, set per phase by the stimulus process
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit hold_requested = 1'b0;
    bit hold_served = 1'b0;
    int hold_left = 0;

    // random phases: mapper kind, item count, sender idling, receiver stalling
    logic [CFG_W-1:0] phase_kind [NUM_PHASES] = '{MAPPER_MBC1, MAPPER_MBC3, MAPPER_MBC5,
        MAPPER_MBC1, MAPPER_MBC3, MAPPER_MBC5, MAPPER_NONE, MAPPER_KIND_TOP};
    int phase_items [NUM_PHASES] = '{220, 220, 220, 220, 220, 220, 65, 65};
    int unsigned phase_idle [NUM_PHASES] = '{0, 77, 0, 20, 0, 77, 0, 20};
    int unsigned phase_stall [NUM_PHASES] = '{0, 0, 77, 20, 0, 0, 77, 20};

    cartridge_bank_controller_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ram bank select: a new bank saves the old window unless the clock was shown
    task automatic select_ram_bank(input logic [BANK_W-1:0] bank, inout bank_result_t res);
        if (model_ram != bank)
        begin
            res.save_old_ram = !model_clock;
            res.load_new_ram = 1'b1;
            model_clock = 1'b0;
            model_ram = bank;
        end
    endtask

    task automatic select_rom_bank(input logic [BANK_W-1:0] bank, inout bank_result_t res);
        if (model_rom != bank)
        begin
            res.remap_rom = 1'b1;
            model_rom = bank;
        end
    endtask

    // predicted effect of one bus write on the bank state
    task automatic apply_bus_write(input bus_write_t w, output bank_result_t res);
        logic [BANK_W-1:0] bank;
        region_t region;
        res = '0;
        region = region_t'(w.addr[14:13]);
        // upper half of the address space never touches the mapper
        if (!w.addr[15])
        begin
            case (model_kind)
                MAPPER_NONE: ;
                MAPPER_MBC1:
                    case (region)
                        REGION_MODE_LATCH: model_mode = w.data[0];
                        REGION_RAM_SELECT:
                            if (model_mode)
                                select_ram_bank(w.data, res);
                            else
                                model_upper = w.data[1:0];
                        REGION_ROM_SELECT:
                        begin
                            bank = {3'b000, w.data[4:0]};
                            if (!model_mode)
                                bank[6:5] = model_upper;
                            // a bank with zero low bits is bumped up by one
                            if (bank[4:0] == 5'd0)
                                bank[0] = 1'b1;
                            select_rom_bank(bank, res);
                        end
                        default: ;
                    endcase
                MAPPER_MBC3:
                    case (region)
                        REGION_RAM_SELECT:
                            if (w.data < MBC3_RAM_BANKS)
                                select_ram_bank(w.data, res);
                            else if (w.data >= MBC3_CLOCK_LO && w.data <= MBC3_CLOCK_HI)
                            begin
                                res.clear_window = 1'b1;
                                model_clock = 1'b1;
                            end
                            else
                                res.ignored = 1'b1;
                        REGION_ROM_SELECT:
                        begin
                            bank = {1'b0, w.data[6:0]};
                            if (bank == '0)
                                bank = 8'd1;
                            select_rom_bank(bank, res);
                        end
                        default: ;  // ram enable and clock latch change nothing
                    endcase
                MAPPER_MBC5:
                    case (region)
                        REGION_RAM_SELECT, REGION_MODE_LATCH: select_ram_bank(w.data, res);
                        REGION_ROM_SELECT: select_rom_bank(w.data, res);
                        default: ;
                    endcase
                default: res.ignored = 1'b1;
            endcase
        end
        res.rom_bank = model_rom;
        res.ram_bank = model_ram;
        res.clock_selected = model_clock;
        res.banking_mode = model_mode;
    endtask

    task automatic check_field(input string name, input logic [BANK_W-1:0] want,
                               input logic [BANK_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        bus_write_t w;
        w.addr = addr;
        w.data = data;
        writes_pending.push_back(w);
    endtask

    // mostly writes into the bank register windows, small data values to hit
    // the mbc3 select codes and repeated banks, the rest anywhere
    function automatic bus_write_t random_write();
        bus_write_t w;
        int unsigned pick;
        w.addr = ADDR_W'($urandom);
        w.data = DATA_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 80)
            w.addr[15:13] = {1'b0, 2'($urandom_range(1, 3))};
        else if (pick < 90)
            w.addr[15:13] = {1'b0, REGION_RAM_ENABLE};
        pick = $urandom_range(99);
        if (pick < 40)
            w.data = DATA_W'($urandom_range(0, 15));
        else if (pick < 50)
            w.data[4:0] = '0;
        return w;
    endfunction

    // all items sent and every result back
    task automatic wait_drained();
        while (writes_pending.size() != 0 || s_axis_tvalid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // mapper kind written only while the block is idle
    task automatic set_mapper(input logic [CFG_W-1:0] kind);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= kind;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_kind = kind;
    endtask

    // driver: keeps an item on offer until it is taken, predicts at acceptance
    always @(posedge clk)
    begin
        bank_result_t res;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                apply_bus_write(bus_write_t'(s_axis_tdata), res);
                results_due.push_back(res);
            end
            if (writes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= writes_pending.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off to back up the pipeline
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_requested && !hold_served)
        begin
            hold_served <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: each result against the oldest prediction
    always @(posedge clk)
    begin
        bank_result_t want;
        bank_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = bank_result_t'(m_axis_tdata[22:0]);
            if (results_due.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("rom_bank", want.rom_bank, got.rom_bank);
                check_field("ram_bank", want.ram_bank, got.ram_bank);
                check_field("clock_selected", want.clock_selected, got.clock_selected);
                check_field("banking_mode", want.banking_mode, got.banking_mode);
                check_field("save_old_ram", want.save_old_ram, got.save_old_ram);
                check_field("load_new_ram", want.load_new_ram, got.load_new_ram);
                check_field("clear_window", want.clear_window, got.clear_window);
                check_field("remap_rom", want.remap_rom, got.remap_rom);
                check_field("ignored", want.ignored, got.ignored);
                check_field("padding", 8'd0, m_axis_tdata[23]);
            end
        end
    end

    // watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no mapper after reset, everything a no-op
        push_write(16'h2000, 8'h05);
        push_write(16'hffff, 8'hff);

        // mbc1: rom bump, upper bits, mode switch and ram select
        set_mapper(MAPPER_MBC1);
        push_write(16'h0000, 8'h0a);
        push_write(16'h2000, 8'h00);
        push_write(16'h3fff, 8'h1f);
        push_write(16'h4000, 8'h03);
        push_write(16'h2000, 8'h20);
        push_write(16'h6000, 8'h01);
        push_write(16'h4000, 8'hff);
        push_write(16'h5fff, 8'hff);
        push_write(16'h2000, 8'h00);
        push_write(16'h7fff, 8'hfe);
        push_write(16'h8000, 8'h00);

        // mbc3: clock select twice, ram bank after clock, bad selects, rom 0
        set_mapper(MAPPER_MBC3);
        push_write(16'h4000, 8'h08);
        push_write(16'h4000, 8'h0c);
        push_write(16'h4000, 8'h02);
        push_write(16'h4000, 8'h05);
        push_write(16'h4000, 8'h0d);
        push_write(16'h2000, 8'h80);
        push_write(16'h6000, 8'h01);

        // mbc5: rom bank 0 kept, full byte ram select from the top window
        set_mapper(MAPPER_MBC5);
        push_write(16'h2000, 8'h00);
        push_write(16'h6000, 8'h07);
        push_write(16'h4000, 8'h07);

        // unknown kind: ignored below the upper half only
        set_mapper(MAPPER_UNKNOWN);
        push_write(16'h1000, 8'h00);
        push_write(16'h8000, 8'h00);

        // random phases with varied traffic, long hold-off in the first one
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_mapper(phase_kind[p]);
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            if (p == 0)
                hold_requested = 1'b1;
            for (int i = 0; i < phase_items[p]; i++)
                writes_pending.push_back(random_write());
        end

        wait_drained();
        repeat (8) @(posedge clk);
        // a prediction still waiting means a result went missing
        if (mismatch_count == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
